/* hdl/wqsl_pkg.sv */
// Package for the step-limited waypoint queue: beat types, codes and constants.
// Used by wqsl_ram's instantiating top level; depends on nothing.
package wqsl_pkg;

   localparam int unsigned COORD_WIDTH         = 32;
   localparam int unsigned STEP_WIDTH          = COORD_WIDTH - 1;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 64;
   localparam int unsigned WP_LEFT_WIDTH       = 7;
   localparam int unsigned CSR_INDEX_WIDTH     = 1;
   localparam int unsigned CSR_DATA_WIDTH      = 31;
   localparam int unsigned SQ_SUM_WIDTH        = 2 * STEP_WIDTH + 2;

   // 0.071 m squared in Q32.32, rounded down; the squared distance is an integer.
   localparam logic [SQ_SUM_WIDTH-1:0] POP_THRESHOLD_SQ = SQ_SUM_WIDTH'(21650930);
   localparam logic [STEP_WIDTH-1:0]   STEP_LIMIT_RESET = STEP_WIDTH'(65536);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_LIMIT        = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GENERATOR_ENABLED = 1'd1;

   // The last code is unused; the block ignores it.
   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_POSITION = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                    operation;
      logic signed [COORD_WIDTH-1:0] coord_x;
      logic signed [COORD_WIDTH-1:0] coord_y;
      logic signed [COORD_WIDTH-1:0] coord_z;
      logic signed [COORD_WIDTH-1:0] heading;
   } req_type;

   typedef struct packed {
      logic                          ref_valid;
      logic signed [COORD_WIDTH-1:0] ref_x;
      logic signed [COORD_WIDTH-1:0] ref_y;
      logic signed [COORD_WIDTH-1:0] ref_z;
      logic signed [COORD_WIDTH-1:0] ref_heading;
      logic [WP_LEFT_WIDTH-1:0]      waypoints_left;
   } rsp_type;

   // One queue entry as it sits in the waypoint memory.
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] heading;
      logic signed [COORD_WIDTH-1:0] z;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] x;
   } entry_type;

endpackage

/* hdl/wqsl_ram.sv */
// Generic single-clock RAM: one write port and one read port with registered read data.
// Depends on nothing.
module wqsl_ram #(
   parameter  int unsigned WIDTH  = 32,
   parameter  int unsigned DEPTH  = 64,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* hdl/waypoint_queue_step_limited_reference_unit.sv */
// Top level of the step-limited waypoint queue: sequencer, shared axis unit and squarer.
// Depends on wqsl_pkg and wqsl_ram.
//
//   channel   ports                                      direction  handshake
//   request   start, busy, req_item                      in         start && !busy
//   response  rsp_valid, rsp_item                        out        one-cycle strobe
//   control   csr_write_enable, csr_index, csr_write_data in        write enable, no wait
//
// A push, a clear or an unknown operation never raises busy. A position beat while the
// generator is disabled or the queue is empty answers in the next cycle without raising
// busy. An active position beat keeps busy high through a difference and a limit state
// per axis, then the square and decide states when the pop test runs, then the emit state;
// the result strobes in the first cycle with busy low again. The single subtract-and-limit
// unit serves each axis twice, and the single squarer serves each axis once.
// Reset is synchronous: it clears the queue and sequencer and resets the control registers.
// The receiver cannot stall: every result beat is on the response ports for one cycle.
module waypoint_queue_step_limited_reference_unit
   import wqsl_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  req_type                    req_item,
   output logic                       rsp_valid,
   output rsp_type                    rsp_item,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned TAIL_W = CNT_W + 1;
   localparam int unsigned CW = COORD_WIDTH;
   localparam int unsigned SW = STEP_WIDTH;
   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIFF,
      S_LIMIT,
      S_SQUARE,
      S_DECIDE,
      S_EMIT
   } state_type;

   // Sequencer and queue bookkeeping.
   state_type         state_ff, state_in;
   logic [1:0]        axis_ff, axis_in;
   logic [1:0]        sq_idx_ff, sq_idx_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SW-1:0]     step_limit_ff, step_limit_in;
   logic              enabled_ff, enabled_in;
   logic              moved_ff, moved_in;
   logic              emit_ff, emit_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers of the shared unit.
   logic signed [CW-1:0]       cur_ff [3];
   logic signed [CW-1:0]       cur_in [3];
   logic signed [CW-1:0]       ref_ff [3];
   logic signed [CW-1:0]       ref_in [3];
   logic [SW-1:0]              absd_ff [3];
   logic [SW-1:0]              absd_in [3];
   logic signed [CW:0]         diff_ff, diff_in;
   logic [2*SW-1:0]            prod_ff, prod_in;
   logic [SQ_SUM_WIDTH-1:0]    sum_ff, sum_in;
   rsp_type                    rsp_item_ff, rsp_item_in;

   // Memory port signals.
   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data;
   logic              ram_rd_en;
   entry_type         ram_rd_data;

   // Combinational helpers.
   logic [TAIL_W-1:0]  tail_sum;
   logic [PTR_W-1:0]   tail;
   logic [PTR_W-1:0]   head_next;
   logic signed [CW-1:0] target;
   logic signed [CW-1:0] cur_sel;
   logic [SW-1:0]      step_eff;
   logic signed [CW:0] step_ext;
   logic [CW:0]        abs_diff;
   logic               limited;
   logic signed [CW:0] limited_ref;
   logic [SW-1:0]      mul_operand;
   logic               pop;

   wqsl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // The tail sits count entries past the head, wrapped once at most.
   assign tail_sum = TAIL_W'(head_ff) + TAIL_W'(count_ff);
   assign tail = (tail_sum >= TAIL_W'(QUEUE_DEPTH)) ?
                 PTR_W'(tail_sum - TAIL_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // A written step limit of zero behaves as one LSB.
   assign step_eff = (step_limit_ff == '0) ? SW'(1) : step_limit_ff;
   assign step_ext = $signed({{(CW + 1 - SW){1'b0}}, step_eff});

   always_comb begin
      case (axis_ff)
         2'd0:    target = ram_rd_data.x;
         2'd1:    target = ram_rd_data.y;
         2'd2:    target = ram_rd_data.z;
         default: target = ram_rd_data.x;
      endcase
      case (axis_ff)
         2'd0:    cur_sel = cur_ff[0];
         2'd1:    cur_sel = cur_ff[1];
         2'd2:    cur_sel = cur_ff[2];
         default: cur_sel = cur_ff[0];
      endcase
      case (sq_idx_ff)
         2'd0:    mul_operand = absd_ff[0];
         2'd1:    mul_operand = absd_ff[1];
         2'd2:    mul_operand = absd_ff[2];
         default: mul_operand = '0;
      endcase
   end

   // Shared limit unit: the magnitude of the registered difference is checked against the
   // step, and the limited reference moves the current position one step toward the target.
   assign abs_diff    = diff_ff[CW] ? $unsigned(-diff_ff) : $unsigned(diff_ff);
   assign limited     = (abs_diff >= $unsigned(step_ext));
   assign limited_ref = diff_ff[CW] ? ({cur_sel[CW-1], cur_sel} - step_ext)
                                    : ({cur_sel[CW-1], cur_sel} + step_ext);

   assign pop = (sum_ff <= POP_THRESHOLD_SQ);

   always_comb begin
      state_in      = state_ff;
      axis_in       = axis_ff;
      sq_idx_in     = sq_idx_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      step_limit_in = step_limit_ff;
      enabled_in    = enabled_ff;
      moved_in      = moved_ff;
      emit_in       = emit_ff;
      rsp_valid_in  = 1'b0;
      cur_in        = cur_ff;
      ref_in        = ref_ff;
      absd_in       = absd_ff;
      diff_in       = diff_ff;
      prod_in       = prod_ff;
      sum_in        = sum_ff;
      rsp_item_in   = rsp_item_ff;

      ram_wr_en           = 1'b0;
      ram_wr_addr         = tail;
      ram_wr_data.x       = req_item.coord_x;
      ram_wr_data.y       = req_item.coord_y;
      ram_wr_data.z       = req_item.coord_z;
      ram_wr_data.heading = req_item.heading;
      ram_rd_en           = 1'b0;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_LIMIT:        step_limit_in = csr_write_data[SW-1:0];
            CSR_GENERATOR_ENABLED: enabled_in    = csr_write_data[0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_item.operation)
                  OP_PUSH: begin
                     // A push to a full queue is dropped.
                     if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                  end
                  OP_POSITION: begin
                     cur_in[0] = req_item.coord_x;
                     cur_in[1] = req_item.coord_y;
                     cur_in[2] = req_item.coord_z;
                     if (enabled_ff && (count_ff != '0)) begin
                        ram_rd_en = 1'b1;
                        axis_in   = 2'd0;
                        moved_in  = 1'b0;
                        state_in  = S_DIFF;
                     end else begin
                        rsp_valid_in                = 1'b1;
                        rsp_item_in                 = '0;
                        rsp_item_in.waypoints_left = WP_LEFT_WIDTH'(count_ff);
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DIFF: begin
            diff_in  = {target[CW-1], target} - {cur_sel[CW-1], cur_sel};
            state_in = S_LIMIT;
         end
         S_LIMIT: begin
            // Only the unlimited magnitudes are squared, and they stay below the step.
            absd_in[axis_ff] = abs_diff[SW-1:0];
            ref_in[axis_ff]  = limited ? limited_ref[CW-1:0] : target;
            moved_in         = moved_ff | limited;
            if (axis_ff == 2'd2) begin
               if (moved_in || (count_ff == CNT_W'(1))) begin
                  emit_in  = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  emit_in   = 1'b0;
                  sq_idx_in = 2'd0;
                  sum_in    = '0;
                  state_in  = S_SQUARE;
               end
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_DIFF;
            end
         end
         S_SQUARE: begin
            // The product of one axis is accumulated while the next one is squared.
            prod_in = mul_operand * mul_operand;
            if (sq_idx_ff != 2'd0) begin
               sum_in = sum_ff + SQ_SUM_WIDTH'(prod_ff);
            end
            if (sq_idx_ff == 2'd3) begin
               state_in = S_DECIDE;
            end else begin
               sq_idx_in = sq_idx_ff + 1'b1;
            end
         end
         S_DECIDE: begin
            if (pop) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_item_in  = '0;
            if (emit_ff) begin
               rsp_item_in.ref_valid   = 1'b1;
               rsp_item_in.ref_x       = ref_ff[0];
               rsp_item_in.ref_y       = ref_ff[1];
               rsp_item_in.ref_z       = ref_ff[2];
               rsp_item_in.ref_heading = ram_rd_data.heading;
               // Reaching the last waypoint without a limited axis empties the queue.
               if (!moved_ff) begin
                  count_in = '0;
                  head_in  = '0;
               end
            end
            rsp_item_in.waypoints_left = WP_LEFT_WIDTH'(count_in);
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      ref_ff      <= ref_in;
      absd_ff     <= absd_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      axis_ff     <= axis_in;
      sq_idx_ff   <= sq_idx_in;
      moved_ff    <= moved_in;
      emit_ff     <= emit_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         step_limit_ff <= STEP_LIMIT_RESET;
         enabled_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         step_limit_ff <= step_limit_in;
         enabled_ff    <= enabled_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The occupancy never runs past the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   // A result beat only follows the emit state or a position beat answered at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff == S_EMIT) ||
                     $past(start && !busy && (req_item.operation == OP_POSITION))))
      else $error("result beat without a position beat");

   // A pop removes exactly one waypoint.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && pop) |=> (count_ff == CNT_W'($past(count_ff) - 1'b1)))
      else $error("pop did not remove exactly one waypoint");

   // Emitting the final waypoint itself leaves the queue empty.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && emit_ff && !moved_ff) |=>
         (count_ff == '0 && rsp_item.waypoints_left == '0))
      else $error("final waypoint emitted but queue not emptied");

endmodule
